// File: sv/jh32_pkg.sv
// ----------------------------------------------------------------------------
// jh32_pkg: shared types and constants of the lookup2 stream hash
// mix word bundle, finalize token and the single mix sub-step function
// ----------------------------------------------------------------------------
package jh32_pkg;

    localparam logic [31:0] GOLDEN    = 32'h9E37_79B9;
    localparam int unsigned MIX_STEPS = 9;

    // position in the 12-byte block: upper bits pick the word, lower bits the lane
    localparam logic [3:0] POS_LAST = 4'd11;
    localparam logic [1:0] GRP_A    = 2'd0;
    localparam logic [1:0] GRP_B    = 2'd1;
    localparam logic [1:0] GRP_C    = 2'd2;
    localparam logic [1:0] LANE_0   = 2'd0;
    localparam logic [1:0] LANE_1   = 2'd1;
    localparam logic [1:0] LANE_2   = 2'd2;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_mix_words;

    // finalize token: tail contributions, optionally on top of the last block result
    typedef struct packed {
        logic       use_pipe;
        t_mix_words add;
    } t_fin_tok;

    // one of the nine sub-steps of the mix
    function automatic t_mix_words mix_sub(input t_mix_words w, input logic [3:0] idx);
        t_mix_words r;
        r = w;
        unique case (idx)
            4'd0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
            4'd1: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
            4'd2: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
            4'd3: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
            4'd4: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
            4'd5: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
            4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
            4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
            4'd8: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

// File: sv/jh32_in_if.sv
// ----------------------------------------------------------------------------
// jh32_in_if: byte stream channel into the hash
// one message byte per transaction with seed and end markers
// ----------------------------------------------------------------------------
interface jh32_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        is_last;
    logic        empty_message;
    logic [31:0] seed;

    modport source (output valid, output data_byte, output is_last,
                    output empty_message, output seed, input ready);
    modport sink   (input valid, input data_byte, input is_last,
                    input empty_message, input seed, output ready);
endinterface

// File: sv/jh32_out_if.sv
// ----------------------------------------------------------------------------
// jh32_out_if: hash result channel
// one 32-bit hash per transaction
// ----------------------------------------------------------------------------
interface jh32_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// File: sv/jh32_mix_pipe.sv
// ----------------------------------------------------------------------------
// jh32_mix_pipe: pipelined lookup2 mix
// input register plus one register per mix sub-step, common advance enable
// ----------------------------------------------------------------------------
module jh32_mix_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  jh32_pkg::t_mix_words i_words,
    output logic                 o_valid,
    output jh32_pkg::t_mix_words o_words,
    output logic                 o_busy
);
    import jh32_pkg::*;

    logic [MIX_STEPS:0] r_vld;
    t_mix_words         r_w [0:MIX_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[MIX_STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_w[0] <= i_words;
            for (int k = 1; k <= MIX_STEPS; k++) begin
                r_w[k] <= mix_sub(r_w[k-1], 4'(k - 1));
            end
        end
    end

    assign o_valid = r_vld[MIX_STEPS];
    assign o_words = r_w[MIX_STEPS];
    assign o_busy  = |r_vld;

endmodule

// File: sv/jenkins_hash32_stream_top.sv
// ----------------------------------------------------------------------------
// jenkins_hash32_stream_top: lookup2 32-bit hash over a byte stream
// one byte per transaction in, one hash per message out
// ----------------------------------------------------------------------------
// usage
//   i_in  : one message byte per transaction; seed is taken on the first
//           transaction of a message, is_last closes it, empty_message marks
//           a transaction without a byte (a lone empty+last is the empty message)
//   o_out : one hash_value transaction per message, in message order
// throughput: one transaction per cycle while the output queue has room, any message length, no gaps
// path: after the last byte is accepted the hash passes the input register,
//   nine mix stages for the block, a join stage, nine mix stages for the
//   final mix, then the output queue
// block mixes run in a 10-deep pipeline; the next block of the same message
//   is at least 12 bytes later, so its result is always back in time
// stall: a two-entry output queue holds finished hashes; input is still
//   taken while one hash waits, and the whole datapath freezes only when
//   both entries are full
// reset: synchronous, active low; clears the message state, pipeline valid
//   bits and the output queue; the first transaction after reset opens a message
// ----------------------------------------------------------------------------
module jenkins_hash32_stream_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jh32_in_if.sink        i_in,
    jh32_out_if.source     o_out
);
    import jh32_pkg::*;

    // pipeline advance, common to every stage
    logic        w_adv;
    logic        w_accept;

    // message state
    logic        r_in_msg;
    logic [3:0]  r_pos;
    logic [31:0] r_len;
    logic [31:0] r_acc_a;
    logic [31:0] r_acc_b;
    logic [23:0] r_hold;
    logic        r_has_blk;
    logic [31:0] r_seed;
    t_mix_words  r_base;

    // current view of the state (fresh values on a message's first transaction)
    logic        w_start;
    logic [3:0]  w_cur_pos;
    logic [31:0] w_cur_len;
    logic [31:0] w_cur_acc_a;
    logic [31:0] w_cur_acc_b;
    logic [23:0] w_cur_hold;
    logic        w_cur_has_blk;
    logic [31:0] w_cur_seed;

    logic [31:0] n_acc_a;
    logic [31:0] n_acc_b;
    logic [23:0] n_hold;
    logic [31:0] n_len;
    logic [3:0]  n_pos;
    logic        w_blk_full;
    t_mix_words  w_init;
    t_mix_words  w_blk_base;
    t_mix_words  w_blk_words;
    t_mix_words  w_tail;
    t_fin_tok    w_tok;

    // block mix pipe and the finalize tokens riding alongside it
    logic        w_p1_vld;
    t_mix_words  w_p1_words;
    logic        w_p1_busy;
    logic [MIX_STEPS:0] r_tok_vld;
    t_fin_tok    r_tok [0:MIX_STEPS];

    // join and final mix
    t_mix_words  w_join_base;
    t_mix_words  w_fin_words;
    logic        w_p2_vld;
    t_mix_words  w_p2_words;
    logic        w_p2_busy;

    // output queue
    logic [31:0] r_q [0:1];
    logic [1:0]  r_q_cnt;
    logic        w_push;
    logic        w_pop;
    logic        w_wr_idx;

    assign w_adv      = (r_q_cnt < 2'd2);
    assign w_accept   = i_in.valid && w_adv;
    assign i_in.ready = w_adv;

    // ------------------------------------------------------------------
    // byte placement into the current block
    // ------------------------------------------------------------------
    always_comb begin
        w_start       = !r_in_msg;
        w_cur_pos     = w_start ? 4'd0 : r_pos;
        w_cur_len     = w_start ? 32'd0 : r_len;
        w_cur_acc_a   = w_start ? 32'd0 : r_acc_a;
        w_cur_acc_b   = w_start ? 32'd0 : r_acc_b;
        w_cur_hold    = w_start ? 24'd0 : r_hold;
        w_cur_has_blk = w_start ? 1'b0 : r_has_blk;
        w_cur_seed    = w_start ? i_in.seed : r_seed;

        n_acc_a = w_cur_acc_a;
        n_acc_b = w_cur_acc_b;
        n_hold  = w_cur_hold;
        // accumulators start at zero each block, so bytes are simply placed
        if (!i_in.empty_message) begin
            unique case (w_cur_pos[3:2])
                GRP_A:   n_acc_a[8*w_cur_pos[1:0] +: 8] = i_in.data_byte;
                GRP_B:   n_acc_b[8*w_cur_pos[1:0] +: 8] = i_in.data_byte;
                GRP_C: begin
                    unique case (w_cur_pos[1:0])
                        LANE_0:  n_hold[7:0]   = i_in.data_byte;
                        LANE_1:  n_hold[15:8]  = i_in.data_byte;
                        LANE_2:  n_hold[23:16] = i_in.data_byte;
                        default: n_hold        = w_cur_hold;
                    endcase
                end
                default: n_acc_a = w_cur_acc_a;
            endcase
        end

        w_blk_full = !i_in.empty_message && (w_cur_pos == POS_LAST);
        n_len      = w_cur_len + {31'd0, !i_in.empty_message};
        if (w_blk_full) begin
            n_pos = 4'd0;
        end else if (i_in.empty_message) begin
            n_pos = w_cur_pos;
        end else begin
            n_pos = w_cur_pos + 4'd1;
        end
    end

    // ------------------------------------------------------------------
    // block job and finalize token
    // ------------------------------------------------------------------
    always_comb begin
        w_init     = {GOLDEN, GOLDEN, w_cur_seed};
        // earlier block of this message has already left the pipe
        w_blk_base = w_cur_has_blk ? r_base : w_init;

        w_blk_words.a = w_blk_base.a + n_acc_a;
        w_blk_words.b = w_blk_base.b + n_acc_b;
        w_blk_words.c = w_blk_base.c + {i_in.data_byte, w_cur_hold};

        // tail bytes for c sit one byte higher than in a full block
        w_tail.a = n_acc_a;
        w_tail.b = n_acc_b;
        w_tail.c = n_len + {n_hold, 8'h00};

        if (w_blk_full) begin
            // block mixed in the same slot; only the length is left for c
            w_tok.use_pipe = 1'b1;
            w_tok.add      = {32'd0, 32'd0, n_len};
        end else if (w_cur_has_blk) begin
            w_tok.use_pipe = 1'b1;
            w_tok.add      = w_tail;
        end else begin
            w_tok.use_pipe = 1'b0;
            w_tok.add.a    = w_init.a + w_tail.a;
            w_tok.add.b    = w_init.b + w_tail.b;
            w_tok.add.c    = w_init.c + w_tail.c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_pos    <= 4'd0;
        end else if (w_accept) begin
            r_in_msg <= !i_in.is_last;
            r_pos    <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len     <= n_len;
            r_acc_a   <= w_blk_full ? 32'd0 : n_acc_a;
            r_acc_b   <= w_blk_full ? 32'd0 : n_acc_b;
            r_hold    <= w_blk_full ? 24'd0 : n_hold;
            r_has_blk <= w_cur_has_blk || w_blk_full;
            r_seed    <= w_cur_seed;
        end
    end

    // ------------------------------------------------------------------
    // block mix pipe with the token line beside it
    // ------------------------------------------------------------------
    jh32_mix_pipe u_blk_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_accept && w_blk_full),
        .i_words (w_blk_words),
        .o_valid (w_p1_vld),
        .o_words (w_p1_words),
        .o_busy  (w_p1_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= '0;
        end else if (w_adv) begin
            r_tok_vld <= {r_tok_vld[MIX_STEPS-1:0], w_accept && i_in.is_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tok[0] <= w_tok;
            for (int k = 1; k <= MIX_STEPS; k++) begin
                r_tok[k] <= r_tok[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // join: last block result plus tail, or the tail token alone, into the final mix
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_adv && w_p1_vld) begin
            r_base <= w_p1_words;
        end
    end

    always_comb begin
        w_join_base = w_p1_vld ? w_p1_words : r_base;
        if (r_tok[MIX_STEPS].use_pipe) begin
            w_fin_words.a = w_join_base.a + r_tok[MIX_STEPS].add.a;
            w_fin_words.b = w_join_base.b + r_tok[MIX_STEPS].add.b;
            w_fin_words.c = w_join_base.c + r_tok[MIX_STEPS].add.c;
        end else begin
            w_fin_words = r_tok[MIX_STEPS].add;
        end
    end

    jh32_mix_pipe u_fin_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_tok_vld[MIX_STEPS]),
        .i_words (w_fin_words),
        .o_valid (w_p2_vld),
        .o_words (w_p2_words),
        .o_busy  (w_p2_busy)
    );

    // ------------------------------------------------------------------
    // two-entry output queue, head in entry 0
    // ------------------------------------------------------------------
    assign w_pop    = (r_q_cnt != 2'd0) && o_out.ready;
    assign w_push   = w_adv && w_p2_vld;
    assign w_wr_idx = (r_q_cnt == 2'd1) && !w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else begin
            r_q_cnt <= r_q_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // a push into the head wins over the shift from entry 1
    always_ff @(posedge i_clk) begin
        if (w_push && !w_wr_idx) begin
            r_q[0] <= w_p2_words.c;
        end else if (w_pop) begin
            r_q[0] <= r_q[1];
        end
        if (w_push && w_wr_idx) begin
            r_q[1] <= w_p2_words.c;
        end
    end

    assign o_out.valid      = (r_q_cnt != 2'd0);
    assign o_out.hash_value = r_q[0];

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("output queue overflow");

    // block position stays inside the 12-byte block
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("block position out of range");

    // a later block reads r_base, so the previous block mix must be done
    a_base_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_blk_full && w_cur_has_blk) |-> !w_p1_busy)
        else $error("block issued while previous block still mixing");

    // input back-pressure only comes from a full output queue
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_q_cnt == 2'd2 && o_out.valid))
        else $error("input stalled without a full output queue");

    // a hash leaving the final mix always finds room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_p2_busy && w_push) |-> (r_q_cnt != 2'd2))
        else $error("final mix result pushed into full queue");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for jenkins_hash32_stream_top
// streams messages byte by byte with random seeds, idle gaps and output
// stalls, predicts each lookup2 hash locally and compares it in order
// ----------------------------------------------------------------------------
module tb;
    import jh32_pkg::*;

    localparam int unsigned HOLD_AT     = 300;  // accepted transactions before the long output hold
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_WAIT  = 40;

    // one input transaction as queued for the driver
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic        empty_message;
        logic [31:0] seed;
    } t_stream_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jh32_in_if  in_ch ();
    jh32_out_if out_ch ();

    jenkins_hash32_stream_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // stimulus and scoreboard storage
    t_stream_item pending_bytes[$];
    logic [31:0]  expected_hashes[$];
    int unsigned  pushed_cnt   = 0;
    int unsigned  accepted_cnt = 0;
    int unsigned  hashes_seen  = 0;
    int unsigned  empty_marks  = 0;
    int unsigned  longest_msg  = 0;
    int unsigned  full_tails   = 0;
    int unsigned  bad_hashes   = 0;

    // predicted hash state of the message in progress
    logic [31:0] msg_a        = GOLDEN;
    logic [31:0] msg_b        = GOLDEN;
    logic [31:0] msg_c        = 32'd0;
    logic [31:0] c_lane_bytes = 32'd0;
    logic [3:0]  lane_pos     = 4'd0;
    logic [31:0] msg_len      = 32'd0;
    logic        msg_open     = 1'b0;

    // idle pacing of both sides
    int send_gap   = 0;
    int send_burst = 0;
    int rcv_stall  = 0;
    int rcv_burst  = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    t_stream_item next_item;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // the nine add/subtract/xor/shift rounds of lookup2
    function automatic void scramble_words();
        logic [31:0] a, b, c;
        a = msg_a;
        b = msg_b;
        c = msg_c;
        a = a - b - c; a = a ^ (c >> 13);
        b = b - c - a; b = b ^ (a << 8);
        c = c - a - b; c = c ^ (b >> 13);
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 16);
        c = c - a - b; c = c ^ (b >> 5);
        a = a - b - c; a = a ^ (c >> 3);
        b = b - c - a; b = b ^ (a << 10);
        c = c - a - b; c = c ^ (b >> 15);
        msg_a = a;
        msg_b = b;
        msg_c = c;
    endfunction

    // folds one accepted transaction into the message, returns 1 with the hash
    // when the transaction closes the message
    function automatic bit absorb_byte(input t_stream_item it, output logic [31:0] hash);
        logic [3:0]  p;
        logic [31:0] lane_val;
        hash = 32'd0;
        if (!msg_open) begin
            msg_a        = GOLDEN;
            msg_b        = GOLDEN;
            msg_c        = it.seed;
            c_lane_bytes = 32'd0;
            lane_pos     = 4'd0;
            msg_len      = 32'd0;
            msg_open     = 1'b1;
        end
        if (!it.empty_message) begin
            p = (lane_pos > POS_LAST) ? 4'd0 : lane_pos;
            lane_val = {24'd0, it.data_byte} << (8 * p[1:0]);
            case (p[3:2])
                GRP_A:   msg_a = msg_a + lane_val;
                GRP_B:   msg_b = msg_b + lane_val;
                default: c_lane_bytes = c_lane_bytes | lane_val;
            endcase
            msg_len = msg_len + 32'd1;
            if (p == POS_LAST) begin
                msg_c = msg_c + c_lane_bytes;
                scramble_words();
                c_lane_bytes = 32'd0;
                lane_pos     = 4'd0;
            end else begin
                lane_pos = p + 4'd1;
            end
        end
        if (it.is_last) begin
            // tail bytes for c sit one lane higher than in a full block
            msg_c = msg_c + msg_len + (c_lane_bytes << 8);
            scramble_words();
            hash         = msg_c;
            c_lane_bytes = 32'd0;
            lane_pos     = 4'd0;
            msg_len      = 32'd0;
            msg_open     = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones, plus gap-free runs
    function automatic int idle_len(inout int burst);
        int r;
        if (burst > 0) begin
            burst = burst - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // seeds lean on the extremes now and then
    function automatic logic [31:0] pick_seed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_item(input logic [7:0] data, input logic last, input logic empty,
                             input logic [31:0] seed);
        t_stream_item it;
        it.data_byte     = data;
        it.is_last       = last;
        it.empty_message = empty;
        it.seed          = seed;
        pending_bytes.push_back(it);
        pushed_cnt++;
    endtask

    // a well-formed message with random content; empty markers show up as an
    // opener, in the middle, or as the closer after the final byte
    task automatic push_random_message(input int n_bytes);
        if (n_bytes == 0) begin
            push_item(pick_byte(), 1'b1, 1'b1, pick_seed());
        end else begin
            if ($urandom_range(0, 9) == 0)
                push_item(pick_byte(), 1'b0, 1'b1, pick_seed());
            for (int i = 0; i < n_bytes; i++) begin
                if ($urandom_range(0, 19) == 0)
                    push_item(pick_byte(), 1'b0, 1'b1, pick_seed());
                if (i == n_bytes - 1 && $urandom_range(0, 7) != 0) begin
                    push_item(pick_byte(), 1'b1, 1'b0, pick_seed());
                end else begin
                    push_item(pick_byte(), 1'b0, 1'b0, pick_seed());
                    if (i == n_bytes - 1)
                        push_item(pick_byte(), 1'b1, 1'b1, pick_seed());
                end
            end
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 0;
        if (r < 70) return $urandom_range(1, 16);
        if (r < 95) return $urandom_range(17, 48);
        return $urandom_range(49, 200);
    endfunction

    // blocks the sender until every queued transaction is in and every hash is out
    task automatic wait_all_done();
        while (accepted_cnt != pushed_cnt || expected_hashes.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: one transaction per handshake from the pending queue
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (send_gap > 0) begin
                in_ch.valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (pending_bytes.size() > 0) begin
                next_item = pending_bytes.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.data_byte     <= next_item.data_byte;
                in_ch.is_last       <= next_item.is_last;
                in_ch.empty_message <= next_item.empty_message;
                in_ch.seed          <= next_item.seed;
                send_gap = idle_len(send_burst);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure plus one long hold that fills the block
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            // long hold while the sender keeps offering bytes
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (rcv_stall > 0) begin
            out_ch.ready <= 1'b0;
            rcv_stall = rcv_stall - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rcv_stall = idle_len(rcv_burst);
        end
    end

    // ------------------------------------------------------------------------
    // input monitor: every accepted transaction goes through the predictor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stream_item seen;
        logic [31:0]  hash;
        logic [31:0]  len_now;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            seen.data_byte     = in_ch.data_byte;
            seen.is_last       = in_ch.is_last;
            seen.empty_message = in_ch.empty_message;
            seen.seed          = in_ch.seed;
            if (seen.empty_message)
                empty_marks++;
            len_now = msg_len + (seen.empty_message ? 32'd0 : 32'd1);
            if (seen.is_last && len_now > longest_msg)
                longest_msg = len_now;
            if (absorb_byte(seen, hash)) begin
                expected_hashes.push_back(hash);
                // the closing block was full, so the tail is empty
                if (len_now != 0 && len_now % 12 == 0)
                    full_tails++;
            end
            accepted_cnt++;
        end
    end

    // ------------------------------------------------------------------------
    // output monitor: in-order compare against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            hashes_seen++;
            if (expected_hashes.size() == 0) begin
                if (bad_hashes < 10)
                    $display("%0t: unexpected hash 0x%08h with nothing pending",
                             $realtime, out_ch.hash_value);
                bad_hashes++;
            end else begin
                want = expected_hashes.pop_front();
                if (want !== out_ch.hash_value) begin
                    if (bad_hashes < 10)
                        $display("%0t: hash %0d mismatch: expected 0x%08h, got 0x%08h",
                                 $realtime, hashes_seen, want, out_ch.hash_value);
                    bad_hashes++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // reset, stimulus phases and end of run
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'd0;
        in_ch.is_last       = 1'b0;
        in_ch.empty_message = 1'b0;
        in_ch.seed          = 32'd0;
        out_ch.ready        = 1'b0;
        i_rst_n             = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty message at both seed extremes
        push_item(8'hA5, 1'b1, 1'b1, 32'h0000_0000);
        push_item(8'h5A, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // empty opener takes the seed, later seeds ignored, empty marker
        // mid-message, then an empty closer with no further byte
        push_item(8'h77, 1'b0, 1'b1, 32'h1234_5678);
        push_item(8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
        push_item(8'hFF, 1'b0, 1'b0, 32'h0000_0000);
        push_item(8'h33, 1'b0, 1'b1, 32'hDEAD_BEEF);
        push_item(8'hCC, 1'b1, 1'b1, 32'h0BAD_F00D);
        // single byte message
        push_item(8'h80, 1'b1, 1'b0, 32'hFFFF_FFFF);
        // block full on the last byte: mix twice
        for (int i = 0; i < 12; i++)
            push_item((i % 2 == 0) ? 8'hFF : 8'h00, (i == 11), 1'b0,
                      (i == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
        wait_all_done();

        // first random phase, the long output hold lands in here
        while (pushed_cnt < 520)
            push_random_message(pick_length());
        // sender pause until the block has delivered everything
        wait_all_done();

        while (pushed_cnt < 1020)
            push_random_message(pick_length());
        wait_all_done();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("run covered %0d transactions (%0d empty markers) and %0d hashes,",
                 accepted_cnt, empty_marks, hashes_seen);
        $display("longest message %0d bytes, %0d messages ending on a full block, %0d bad",
                 longest_msg, full_tails, bad_hashes);
        if (bad_hashes == 0) begin
            $display("** jenkins_hash32_stream_top: PASSED **");
        end else begin
            $display("** jenkins_hash32_stream_top: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout: %0d of %0d transactions in, %0d hashes pending",
                 accepted_cnt, pushed_cnt, expected_hashes.size());
        $display("** jenkins_hash32_stream_top: FAILED **");
        $finish;
    end

endmodule
